// File: rtl/kda_pkg.sv
`timescale 1ns / 1ps

package kda_pkg;

  // default widths of the key code and the tick time
  localparam int KEY_BITS_DEF  = 8;
  localparam int TIME_BITS_DEF = 32;

  // configuration register file
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int DELAY_BITS    = 16;
  localparam int NOKEY_BITS    = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_REPEAT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_NO_KEY       = 3'd4;

  // register reset values
  localparam logic [DELAY_BITS-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [DELAY_BITS-1:0] FIRST_REPEAT_RST = 16'd500;
  localparam logic [DELAY_BITS-1:0] REPEAT_RST       = 16'd100;
  localparam logic [NOKEY_BITS-1:0] NO_KEY_RST       = 8'd0;

  // tracker mode
  typedef enum logic [1:0] {
    MODE_READY  = 2'd0,
    MODE_NEW    = 2'd1,
    MODE_REPEAT = 2'd2
  } kda_mode_t;

  // configuration as seen by the tracker
  typedef struct packed {
    logic                  enable;
    logic [DELAY_BITS-1:0] debounce_delay;
    logic [DELAY_BITS-1:0] first_repeat_delay;
    logic [DELAY_BITS-1:0] repeat_delay;
    logic [NOKEY_BITS-1:0] no_key_code;
  } kda_cfg_t;

endpackage

// File: rtl/key_debounce_autorepeat.sv
`timescale 1ns / 1ps

// Debounced key scanner with typematic repeat. Each input transaction is one
// tick: the free-running time and the scanned key code. A key must hold
// debounce_delay ticks before its first press is reported, then repeats after
// first_repeat_delay and every repeat_delay ticks after that; the no-key code
// returns the tracker to ready. One tick is taken every clock cycle unless the
// output register is full and not drained; each report lands in a single
// output register that is refilled in the cycle it is taken. Deadlines wrap
// modulo 2^TIME_BITS and are compared unsigned. The user writes configuration
// through cfg_we/cfg_index/cfg_wdata only while no tick is in flight; the
// block does not enforce this. Writing the enable register restarts the tracker.
module key_debounce_autorepeat #(
  parameter int KEY_BITS  = kda_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = kda_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [kda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [kda_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // tick input
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: now, key_code, zero pad
  input  logic [((TIME_BITS+KEY_BITS+7)/8)*8-1:0] in_tdata,
  // key report output
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: pressed_key, zero pad
  output logic [((KEY_BITS+7)/8)*8-1:0] out_tdata
);
  import kda_pkg::*;

  localparam int OUT_W = ((KEY_BITS + 7) / 8) * 8;

  kda_cfg_t             cfg_r;
  logic                 in_accept;
  logic                 cfg_clear;
  logic [TIME_BITS-1:0] in_now;
  logic [KEY_BITS-1:0]  in_key;
  logic                 trk_hit;
  logic [KEY_BITS-1:0]  trk_key;
  logic                 out_valid_r;
  logic [KEY_BITS-1:0]  out_key_r;

  assign in_now    = in_tdata[TIME_BITS-1:0];
  assign in_key    = in_tdata[TIME_BITS+KEY_BITS-1:TIME_BITS];
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_clear = cfg_we && (cfg_index == REG_ENABLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable             <= 1'b0;
      cfg_r.debounce_delay     <= DEBOUNCE_RST;
      cfg_r.first_repeat_delay <= FIRST_REPEAT_RST;
      cfg_r.repeat_delay       <= REPEAT_RST;
      cfg_r.no_key_code        <= NO_KEY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       cfg_r.enable             <= cfg_wdata[0];
        REG_DEBOUNCE:     cfg_r.debounce_delay     <= cfg_wdata[DELAY_BITS-1:0];
        REG_FIRST_REPEAT: cfg_r.first_repeat_delay <= cfg_wdata[DELAY_BITS-1:0];
        REG_REPEAT:       cfg_r.repeat_delay       <= cfg_wdata[DELAY_BITS-1:0];
        REG_NO_KEY:       cfg_r.no_key_code        <= cfg_wdata[NOKEY_BITS-1:0];
        default:          ;
      endcase
    end
  end

  kda_tracker #(
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_tracker (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_accept),
    .clear    (cfg_clear),
    .cfg      (cfg_r),
    .now      (in_now),
    .key_code (in_key),
    .hit      (trk_hit),
    .hit_key  (trk_key)
  );

  // output register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && trk_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && trk_hit) begin
      out_key_r <= trk_key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_key_r);

  // a report is only raised while the tracker is enabled
  a_hit_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && trk_hit) |-> cfg_r.enable)
    else $error("report raised while disabled");

  // a report always carries the key of the tick that raised it
  a_hit_key: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && trk_hit) |-> (trk_key == in_key))
    else $error("report key differs from tick key");

  // a new transaction on the output needs a tick accepted just before
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept))
    else $error("output raised without an accepted tick");

endmodule

// File: rtl/kda_tracker.sv
`timescale 1ns / 1ps

module kda_tracker #(
  parameter int KEY_BITS  = kda_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = kda_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic                 clear,
  input  kda_pkg::kda_cfg_t    cfg,
  input  logic [TIME_BITS-1:0] now,
  input  logic [KEY_BITS-1:0]  key_code,
  output logic                 hit,
  output logic [KEY_BITS-1:0]  hit_key
);
  import kda_pkg::*;

  kda_mode_t            mode_r, mode_nxt;
  logic [KEY_BITS-1:0]  held_key_r, held_key_nxt;
  logic [TIME_BITS-1:0] deadline_r, deadline_nxt;
  logic [DELAY_BITS-1:0] next_delay;
  logic                 is_no_key;

  assign is_no_key = (key_code == KEY_BITS'(cfg.no_key_code));
  assign hit_key   = held_key_r;

  // delay that follows a report: first repeat after the first press, else repeat
  always_comb begin
    case (mode_r)
      MODE_NEW: next_delay = cfg.first_repeat_delay;
      default:  next_delay = cfg.repeat_delay;
    endcase
  end

  // one tick of the debounce and repeat tracker
  always_comb begin
    mode_nxt     = mode_r;
    held_key_nxt = held_key_r;
    deadline_nxt = deadline_r;
    hit          = 1'b0;
    if (step && cfg.enable) begin
      if (is_no_key) begin
        mode_nxt = MODE_READY;
      end else if (mode_r == MODE_READY || held_key_r != key_code) begin
        held_key_nxt = key_code;
        mode_nxt     = MODE_NEW;
        deadline_nxt = now + TIME_BITS'(cfg.debounce_delay);
      end else if (now >= deadline_r) begin
        hit          = 1'b1;
        mode_nxt     = MODE_REPEAT;
        deadline_nxt = now + TIME_BITS'(next_delay);
      end
    end
    // a write to the enable register restarts the tracker
    if (clear) begin
      mode_nxt = MODE_READY;
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_READY;
      held_key_r <= '0;
      deadline_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      held_key_r <= held_key_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule
